/* sv/lfdw_pkg.sv */
// ----------------------------------------------------------------------------
// Line follower package
// Shared widths, register indexes and constants for the line follower and its
// serial arithmetic units.
// ----------------------------------------------------------------------------
package lfdw_pkg;

  localparam int SENSOR_BITS_DEF = 12;
  localparam int COUNT_BITS_DEF  = 16;

  localparam int GW   = 16;  // gain width
  localparam int MB   = 34;  // multiplicand width
  localparam int MP   = 50;  // product width
  localparam int SUMW = 52;  // PID sum width
  localparam int DW   = 55;  // dividend width
  localparam int DVW  = 12;  // divisor width

  typedef enum logic [2:0] {
    REG_STEER_KP   = 3'd0,
    REG_STEER_KI   = 3'd1,
    REG_STEER_KD   = 3'd2,
    REG_WHEEL_KP   = 3'd3,
    REG_WHEEL_KI   = 3'd4,
    REG_WHEEL_KD   = 3'd5,
    REG_BASE_SPEED = 3'd6,
    REG_MAX_SPEED  = 3'd7
  } reg_idx_t;

  localparam logic [15:0] BASE_SPEED_RST = 16'd2000;
  localparam logic [15:0] MAX_SPEED_RST  = 16'd3800;
  localparam logic [16:0] DUTY_HALF      = 17'd32768;
  localparam logic [16:0] DUTY_FULL      = 17'd65536;
  localparam int          LINE_MV        = 500;
  localparam int          DARK_MV        = 150;
  localparam int          FLAT_DEV       = 3600;
  localparam int          TURN_SPEED     = 1000;
  localparam logic signed [GW-1:0] SPEED_SCALE = 16'sd10000;
  localparam logic [DVW-1:0] STEER_DIV   = 12'd2560;
  localparam logic [DVW-1:0] DUTY_DIV    = 12'd625;

endpackage

/* sv/lfdw_mul.sv */
// ----------------------------------------------------------------------------
// Serial signed multiplier
// Shift-and-add multiplier that consumes one gain bit per cycle.
// ----------------------------------------------------------------------------
module lfdw_mul (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [lfdw_pkg::GW-1:0]    a,
  input  logic signed [lfdw_pkg::MB-1:0]    b,
  output logic                              done,
  output logic signed [lfdw_pkg::MP-1:0]    prod
);

  localparam int CW = $clog2(lfdw_pkg::GW);

  logic signed [lfdw_pkg::MP-1:0] acc;
  logic signed [lfdw_pkg::MP-1:0] bsh;
  logic [lfdw_pkg::GW-1:0]        ash;
  logic [CW-1:0]                  cnt;
  logic                           busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc  <= '0;
        bsh  <= lfdw_pkg::MP'(b);
        ash  <= a;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        // The top gain bit carries negative weight.
        if (ash[0]) begin
          acc <= (cnt == CW'(lfdw_pkg::GW - 1)) ? acc - bsh : acc + bsh;
        end
        bsh <= bsh <<< 1;
        ash <= ash >> 1;
        cnt <= cnt + CW'(1);
        if (cnt == CW'(lfdw_pkg::GW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc;

endmodule

/* sv/lfdw_div.sv */
// ----------------------------------------------------------------------------
// Serial floor divider
// Restoring divider, one quotient bit per cycle, rounding toward minus
// infinity.
// ----------------------------------------------------------------------------
module lfdw_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [lfdw_pkg::DW-1:0]    x,
  input  logic [lfdw_pkg::DVW-1:0]          dv,
  output logic                              done,
  output logic signed [lfdw_pkg::DW-1:0]    q
);

  localparam int MW = lfdw_pkg::DW + 1;
  localparam int CW = $clog2(MW);
  localparam int VW = lfdw_pkg::DVW;

  logic [MW-1:0] dsh;
  logic [VW-1:0] rem;
  logic [CW-1:0] cnt;
  logic          neg;
  logic          busy;
  logic [MW-1:0] xe;
  logic [MW-1:0] mag;
  logic [VW:0]   r2;
  logic          ge;
  logic [lfdw_pkg::DW-1:0] qm;

  // For a negative dividend, floor(x/d) = -((-x + d - 1) / d), and -x + d - 1
  // equals ~x + d.
  assign xe  = {x[lfdw_pkg::DW-1], x};
  assign mag = xe[MW-1] ? (~xe) + MW'(dv) : xe;
  assign r2  = {rem, dsh[MW-1]};
  assign ge  = (r2 >= {1'b0, dv});
  assign qm  = dsh[lfdw_pkg::DW-1:0];
  assign q   = neg ? $signed(lfdw_pkg::DW'(~qm + lfdw_pkg::DW'(1))) : $signed(qm);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg  <= x[lfdw_pkg::DW-1];
        dsh  <= mag;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? VW'(r2 - {1'b0, dv}) : r2[VW-1:0];
        dsh <= {dsh[MW-2:0], ge};
        cnt <= cnt + CW'(1);
        if (cnt == CW'(MW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* sv/line_follow_dual_wheel_pid.sv */
// ----------------------------------------------------------------------------
// Dual wheel PID line follower
// A new beat is accepted in the cycle after the result is loaded; the result
// waits in the done state while the output is stalled. All products come from
// one shared serial multiplier and all quotients from one serial divider.
// Reset is synchronous: gains clear, speeds return to 2000 and 3800, duty
// accumulators return to half scale, and integrators, last errors, previous
// counts, goals, lost and spin flags, pending flags and output valid clear.
// ----------------------------------------------------------------------------
module line_follow_dual_wheel_pid #(
  parameter int SENSOR_BITS = lfdw_pkg::SENSOR_BITS_DEF,
  parameter int COUNT_BITS  = lfdw_pkg::COUNT_BITS_DEF,
  localparam int IN_W = ((6 * SENSOR_BITS + 2 * COUNT_BITS + 2 + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // sensor_1..sensor_6, left_count, right_count, run_mode, spin_request
  input  logic [IN_W-1:0] s_axis_tdata,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // left_duty, right_duty, left_speed, right_speed, left_target, right_target
  output logic [135:0]    m_axis_tdata,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [15:0]     cfg_data
);

  localparam int SB   = SENSOR_BITS;
  localparam int CB   = COUNT_BITS;
  localparam int SV_W = (SB < 10) ? 10 : SB;
  localparam int MB   = lfdw_pkg::MB;
  localparam int MP   = lfdw_pkg::MP;
  localparam int SUMW = lfdw_pkg::SUMW;
  localparam int DW   = lfdw_pkg::DW;

  localparam logic signed [SUMW-1:0] WI_MAX  = SUMW'({47{1'b1}});
  localparam logic signed [SUMW-1:0] WI_MIN  = ~WI_MAX;
  localparam logic signed [SUMW-1:0] SI_MAX  = SUMW'({39{1'b1}});
  localparam logic signed [SUMW-1:0] SI_MIN  = ~SI_MAX;
  localparam logic signed [MP-1:0]   SPD_MAX = MP'({31{1'b1}});
  localparam logic signed [MP-1:0]   SPD_MIN = ~SPD_MAX;
  localparam logic signed [17:0]     TURN_P  = 18'(lfdw_pkg::TURN_SPEED);
  localparam logic signed [17:0]     TURN_N  = -18'(lfdw_pkg::TURN_SPEED);

  typedef enum logic [15:0] {
    ST_IDLE   = 16'h0001,
    ST_DECIDE = 16'h0002,
    ST_DEV    = 16'h0004,
    ST_SP     = 16'h0008,
    ST_SI     = 16'h0010,
    ST_SD     = 16'h0020,
    ST_SDIV   = 16'h0040,
    ST_SGOAL  = 16'h0080,
    ST_SPDL   = 16'h0100,
    ST_SPDR   = 16'h0200,
    ST_WERR   = 16'h0400,
    ST_WP     = 16'h0800,
    ST_WI     = 16'h1000,
    ST_WD     = 16'h2000,
    ST_WDIV   = 16'h4000,
    ST_DONE   = 16'h8000
  } state_t;

  state_t state;

  logic signed [15:0] steer_kp, steer_ki, steer_kd;
  logic signed [15:0] wheel_kp, wheel_ki, wheel_kd;
  logic [15:0]        base_speed, max_speed;

  logic [SV_W-1:0] sv [6];
  logic [CB-1:0]   lc, rc, prev_l, prev_r;
  logic            run, spin_req;
  logic            spin_active, lost_r, lost_l;

  logic signed [39:0]   st_integ;
  logic signed [15:0]   st_last, e_st;
  logic signed [23:0]   total_r;
  logic                 dev_big;
  logic signed [33:0]   u_reg;
  logic signed [SUMW-1:0] sum_r;
  logic signed [33:0]   e_w;
  logic                 side;
  logic signed [47:0]   integ_l, integ_r;
  logic signed [32:0]   last_l, last_r;
  logic [16:0]          acc_l, acc_r;
  logic signed [17:0]   lgoal, rgoal;
  logic signed [31:0]   lspd, rspd;
  logic                 mul_pend, div_pend;

  logic [SV_W-1:0]       clean [6];
  logic                  gt [6];
  logic signed [23:0]    sx [6];
  logic signed [23:0]    es, total, dev6;
  logic signed [15:0]    e_cl;
  logic                  lr, ll;

  logic                    mul_start, mul_done;
  logic signed [15:0]      mul_a;
  logic signed [MB-1:0]    mul_b;
  logic signed [MP-1:0]    mul_prod;
  logic                    div_start, div_done;
  logic signed [DW-1:0]    div_x, div_q;
  logic [lfdw_pkg::DVW-1:0] div_d;

  logic signed [CB-1:0]   diff_l, diff_r;
  logic signed [MP-1:0]   spd_sat;
  logic signed [47:0]     integ_side;
  logic signed [32:0]     last_side;
  logic [16:0]            acc_side;
  logic signed [SUMW-1:0] wi_sum, wi_new, si_sum, si_new;
  logic signed [DW:0]     acc_sum;
  logic [16:0]            acc_new;
  logic signed [35:0]     gb, gm, gu, gl1, gr1, gl, gr;
  logic signed [17:0]     gl_c, gr_c;
  logic [15:0]            duty_l, duty_r;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      clean[i] = (32'(s_axis_tdata[i*SB +: SB]) < 32'(lfdw_pkg::LINE_MV))
                 ? SV_W'(lfdw_pkg::DARK_MV) : SV_W'(s_axis_tdata[i*SB +: SB]);
      gt[i]    = 32'(sv[i]) > 32'(lfdw_pkg::LINE_MV);
      sx[i]    = $signed(24'(sv[i]));
    end
  end

  always_comb begin
    es    = -((sx[3] - sx[2]) + 24'sd9 * (sx[4] - sx[1]));
    e_cl  = (es > 24'sd32767) ? 16'sh7FFF : (es < -24'sd32768) ? 16'sh8000 : es[15:0];
    total = sx[0] + sx[1] + sx[2] + sx[3] + sx[4] + sx[5];
    dev6  = '0;
    for (int i = 0; i < 6; i++) begin
      if (24'sd6 * sx[i] - total_r < 0) begin
        dev6 = dev6 - (24'sd6 * sx[i] - total_r);
      end else begin
        dev6 = dev6 + (24'sd6 * sx[i] - total_r);
      end
    end
    lr = lost_r | gt[5];
    ll = lost_l | (!gt[5] & gt[0]);
  end

  assign diff_l     = $signed(lc - prev_l);
  assign diff_r     = $signed(rc - prev_r);
  assign integ_side = side ? integ_r : integ_l;
  assign last_side  = side ? last_r : last_l;
  assign acc_side   = side ? acc_r : acc_l;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SP: begin
        mul_a = steer_kp;
        mul_b = MB'(e_st);
      end
      ST_SI: begin
        mul_a = steer_ki;
        mul_b = MB'(e_st);
      end
      ST_SD: begin
        mul_a = steer_kd;
        mul_b = MB'(e_st) - MB'(st_last);
      end
      ST_SPDL: begin
        mul_a = lfdw_pkg::SPEED_SCALE;
        mul_b = MB'(diff_l);
      end
      ST_SPDR: begin
        mul_a = lfdw_pkg::SPEED_SCALE;
        mul_b = MB'(diff_r);
      end
      ST_WP: begin
        mul_a = wheel_kp;
        mul_b = e_w;
      end
      ST_WI: begin
        mul_a = wheel_ki;
        mul_b = e_w;
      end
      ST_WD: begin
        mul_a = wheel_kd;
        mul_b = e_w - MB'(last_side);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_start = !mul_pend && (state == ST_SP || state == ST_SI || state == ST_SD ||
                     state == ST_SPDL || state == ST_SPDR || state == ST_WP ||
                     state == ST_WI || state == ST_WD);
  assign div_start = !div_pend && (state == ST_SDIV || state == ST_WDIV);
  assign div_x     = (state == ST_SDIV) ? DW'(sum_r) : (DW'(sum_r) <<< 3);
  assign div_d     = (state == ST_SDIV) ? lfdw_pkg::STEER_DIV : lfdw_pkg::DUTY_DIV;

  lfdw_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  lfdw_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .x     (div_x),
    .dv    (div_d),
    .done  (div_done),
    .q     (div_q)
  );

  always_comb begin
    spd_sat = (mul_prod > SPD_MAX) ? SPD_MAX : (mul_prod < SPD_MIN) ? SPD_MIN : mul_prod;
    wi_sum  = SUMW'(integ_side) + SUMW'(mul_prod);
    wi_new  = (wi_sum > WI_MAX) ? WI_MAX : (wi_sum < WI_MIN) ? WI_MIN : wi_sum;
    si_sum  = SUMW'(st_integ) + SUMW'(mul_prod);
    si_new  = (si_sum > SI_MAX) ? SI_MAX : (si_sum < SI_MIN) ? SI_MIN : si_sum;
    acc_sum = (DW+1)'(div_q) + $signed((DW+1)'(acc_side));
    acc_new = (acc_sum < 0) ? 17'd0 :
              (acc_sum > $signed((DW+1)'(lfdw_pkg::DUTY_FULL))) ? lfdw_pkg::DUTY_FULL :
              acc_sum[16:0];
  end

  always_comb begin
    gb  = $signed(36'(base_speed));
    gm  = $signed(36'(max_speed));
    gu  = 36'(u_reg);
    gl1 = gb - gu;
    gr1 = gb + gu;
    if (gl1 > gm) begin
      gl = gm;
      gr = 36'sd2 * gu + gm;
    end else if (gr1 > gm) begin
      gr = gm;
      gl = gm - 36'sd2 * gu;
    end else begin
      gl = gl1;
      gr = gr1;
    end
    if (!dev_big) begin
      gl = '0;
      gr = '0;
    end
    gl_c = (gl > 36'sd65535) ? 18'sd65535 : (gl < -36'sd65536) ? -18'sd65536 : gl[17:0];
    gr_c = (gr > 36'sd65535) ? 18'sd65535 : (gr < -36'sd65536) ? -18'sd65536 : gr[17:0];
  end

  assign duty_l = acc_l[16] ? 16'hFFFF : acc_l[15:0];
  assign duty_r = acc_r[16] ? 16'hFFFF : acc_r[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      steer_kp      <= '0;
      steer_ki      <= '0;
      steer_kd      <= '0;
      wheel_kp      <= '0;
      wheel_ki      <= '0;
      wheel_kd      <= '0;
      base_speed    <= lfdw_pkg::BASE_SPEED_RST;
      max_speed     <= lfdw_pkg::MAX_SPEED_RST;
      spin_active   <= 1'b0;
      lost_r        <= 1'b0;
      lost_l        <= 1'b0;
      st_integ      <= '0;
      st_last       <= '0;
      integ_l       <= '0;
      integ_r       <= '0;
      last_l        <= '0;
      last_r        <= '0;
      prev_l        <= '0;
      prev_r        <= '0;
      acc_l         <= lfdw_pkg::DUTY_HALF;
      acc_r         <= lfdw_pkg::DUTY_HALF;
      lgoal         <= '0;
      rgoal         <= '0;
      mul_pend      <= 1'b0;
      div_pend      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (lfdw_pkg::reg_idx_t'(cfg_index))
          lfdw_pkg::REG_STEER_KP:   steer_kp   <= $signed(cfg_data);
          lfdw_pkg::REG_STEER_KI:   steer_ki   <= $signed(cfg_data);
          lfdw_pkg::REG_STEER_KD:   steer_kd   <= $signed(cfg_data);
          lfdw_pkg::REG_WHEEL_KP:   wheel_kp   <= $signed(cfg_data);
          lfdw_pkg::REG_WHEEL_KI:   wheel_ki   <= $signed(cfg_data);
          lfdw_pkg::REG_WHEEL_KD:   wheel_kd   <= $signed(cfg_data);
          lfdw_pkg::REG_BASE_SPEED: base_speed <= cfg_data;
          lfdw_pkg::REG_MAX_SPEED:  max_speed  <= cfg_data;
          default: ;
        endcase
      end

      if (mul_start) begin
        mul_pend <= 1'b1;
      end else if (mul_done) begin
        mul_pend <= 1'b0;
      end
      if (div_start) begin
        div_pend <= 1'b1;
      end else if (div_done) begin
        div_pend <= 1'b0;
      end

      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            for (int i = 0; i < 6; i++) begin
              sv[i] <= clean[i];
            end
            lc       <= s_axis_tdata[6*SB +: CB];
            rc       <= s_axis_tdata[6*SB+CB +: CB];
            run      <= s_axis_tdata[6*SB+2*CB];
            spin_req <= s_axis_tdata[6*SB+2*CB+1];
            state    <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (!run) begin
            spin_active <= spin_active | spin_req;
            state       <= ST_SPDL;
          end else if (spin_active | spin_req) begin
            lgoal       <= TURN_P;
            rgoal       <= TURN_N;
            spin_active <= !(gt[4] | gt[2]);
            state       <= ST_SPDL;
          end else if (gt[0] | gt[5] | lost_r | lost_l) begin
            if (lr) begin
              lgoal <= $signed(18'(max_speed));
              rgoal <= TURN_N;
              if (gt[4]) begin
                lost_r <= 1'b0;
                lost_l <= 1'b0;
              end else begin
                lost_r <= lr;
                lost_l <= ll;
              end
            end else begin
              lgoal <= TURN_N;
              rgoal <= $signed(18'(max_speed));
              if (gt[1]) begin
                lost_r <= 1'b0;
                lost_l <= 1'b0;
              end else begin
                lost_r <= lr;
                lost_l <= ll;
              end
            end
            state <= ST_SPDL;
          end else begin
            e_st    <= e_cl;
            total_r <= total;
            state   <= ST_DEV;
          end
        end
        ST_DEV: begin
          dev_big <= dev6 > 24'(lfdw_pkg::FLAT_DEV);
          state   <= ST_SP;
        end
        ST_SP: begin
          if (mul_done) begin
            sum_r <= SUMW'(mul_prod);
            state <= ST_SI;
          end
        end
        ST_SI: begin
          if (mul_done) begin
            st_integ <= si_new[39:0];
            sum_r    <= sum_r + si_new;
            state    <= ST_SD;
          end
        end
        ST_SD: begin
          if (mul_done) begin
            st_last <= e_st;
            sum_r   <= sum_r + SUMW'(mul_prod);
            state   <= ST_SDIV;
          end
        end
        ST_SDIV: begin
          if (div_done) begin
            u_reg <= div_q[33:0];
            state <= ST_SGOAL;
          end
        end
        ST_SGOAL: begin
          lgoal <= gl_c;
          rgoal <= gr_c;
          state <= ST_SPDL;
        end
        ST_SPDL: begin
          if (mul_done) begin
            lspd   <= spd_sat[31:0];
            prev_l <= lc;
            state  <= ST_SPDR;
          end
        end
        ST_SPDR: begin
          if (mul_done) begin
            rspd   <= spd_sat[31:0];
            prev_r <= rc;
            side   <= 1'b0;
            state  <= ST_WERR;
          end
        end
        ST_WERR: begin
          e_w   <= side ? (MB'(rgoal) - MB'(rspd)) : (MB'(lgoal) - MB'(lspd));
          state <= ST_WP;
        end
        ST_WP: begin
          if (mul_done) begin
            sum_r <= SUMW'(mul_prod);
            state <= ST_WI;
          end
        end
        ST_WI: begin
          if (mul_done) begin
            if (side) begin
              integ_r <= wi_new[47:0];
            end else begin
              integ_l <= wi_new[47:0];
            end
            sum_r <= sum_r + wi_new;
            state <= ST_WD;
          end
        end
        ST_WD: begin
          if (mul_done) begin
            if (side) begin
              last_r <= e_w[32:0];
            end else begin
              last_l <= e_w[32:0];
            end
            sum_r <= sum_r + SUMW'(mul_prod);
            state <= ST_WDIV;
          end
        end
        ST_WDIV: begin
          if (div_done) begin
            if (side) begin
              acc_r <= acc_new;
              state <= ST_DONE;
            end else begin
              acc_l <= acc_new;
              side  <= 1'b1;
              state <= ST_WERR;
            end
          end
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {6'b0, rgoal[16:0], lgoal[16:0], rspd, lspd, duty_r, duty_l};
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/lfdw_chk.sv */
// ----------------------------------------------------------------------------
// Line follower port checker
// Watches the stream ports of the line follower over time.
// ----------------------------------------------------------------------------
module lfdw_chk (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a beat is in work");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared one cycle after accept");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind line_follow_dual_wheel_pid lfdw_chk u_lfdw_chk (.*);
